FILE: hdl/char_lcd_cursor_controller_assert.svh
// assertion macros used by the checker file
// each macro expands to one labeled concurrent assertion clocked on clk
// with arst_n low disabling the check
`ifndef CHAR_LCD_CURSOR_CONTROLLER_ASSERT_SVH
`define CHAR_LCD_CURSOR_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define CLCD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clcd assertion failed");

// next-cycle implication
`define CLCD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clcd assertion failed");

`endif

FILE: hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, codes and constants of the character display cursor controller.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

	// default number of cells on one display line
	localparam int LINE_CHARS_DEF = 16;
	localparam int COL_W_DEF      = $clog2(LINE_CHARS_DEF + 1);

	// width of the address field inside the set-address instruction
	localparam int ADDR_FIELD_W = 6;

	// command codes
	typedef enum logic [3:0] {
		FN_PUT_CHAR  = 4'd0,
		FN_CLEAR     = 4'd1,
		FN_CLEAR_EOL = 4'd2,
		FN_UP        = 4'd3,
		FN_DOWN      = 4'd4,
		FN_RIGHT     = 4'd5,
		FN_LEFT      = 4'd6,
		FN_SET_POS   = 4'd7,
		FN_GET_POS   = 4'd8
	} func_t;

	// bus write kinds
	typedef enum logic [1:0] {
		BUS_NONE  = 2'd0,
		BUS_INSTR = 2'd1,
		BUS_DATA  = 2'd2
	} bus_kind_t;

	// what the final word of a command carries
	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_ADDR,
		FIN_CLEAR
	} fin_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT
	} state_t;

	// display controller bytes
	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] INSTR_CLEAR   = 8'h01;
	localparam logic [7:0] PRINT_LO_MIN  = 8'h20;
	localparam logic [7:0] PRINT_LO_MAX  = 8'h7F;
	localparam logic [7:0] PRINT_HI_MIN  = 8'hA0;
	localparam logic [7:0] PRINT_HI_END  = 8'hFF;

	// row numbers as reported
	localparam logic [1:0] ROW_TOP    = 2'd1;
	localparam logic [1:0] ROW_BOTTOM = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic push;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic more;
	} dp_status_t;

	// printable character test
	function automatic logic is_printable(logic [7:0] c);
		return ((c >= PRINT_LO_MIN) && (c <= PRINT_LO_MAX)) ||
			((c >= PRINT_HI_MIN) && (c < PRINT_HI_END));
	endfunction

endpackage

`default_nettype wire

FILE: hdl/clcd_cmd_if.sv
// ----------------------------------------------------------------------------
// clcd_cmd_if
// Command channel: valid/ready handshake with one command per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface clcd_cmd_if;
	logic       valid;
	logic       ready;
	logic [3:0] func;
	logic [7:0] char_code;
	logic [1:0] req_row;
	logic [4:0] req_column;

	modport source (output valid, output func, output char_code, output req_row,
		output req_column, input ready);
	modport sink (input valid, input func, input char_code, input req_row,
		input req_column, output ready);
endinterface

`default_nettype wire

FILE: hdl/clcd_res_if.sv
// ----------------------------------------------------------------------------
// clcd_res_if
// Result channel: one display bus write per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface clcd_res_if #(
	parameter int COL_W = clcd_pkg::COL_W_DEF
);
	logic             valid;
	logic             ready;
	logic [1:0]       bus_kind;
	logic [7:0]       bus_byte;
	logic             ok;
	logic [1:0]       cur_row;
	logic [COL_W-1:0] cur_column;
	logic             last;

	modport source (output valid, output bus_kind, output bus_byte, output ok,
		output cur_row, output cur_column, output last, input ready);
	modport sink (input valid, input bus_kind, input bus_byte, input ok,
		input cur_row, input cur_column, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/clcd_ctrl.sv
// ----------------------------------------------------------------------------
// clcd_ctrl
// Sequencer: takes a command, runs the cursor update, then pushes the bus
// words into the output register one per cycle as the receiver allows.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	input  clcd_pkg::dp_status_t  status,
	output clcd_pkg::ctrl_cmd_t   ctrl
);
	import clcd_pkg::*;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   push;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		cmd_ready = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				push      = !res_valid_q || res_ready;
				ctrl.push = push;
				if (push && !status.more) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

FILE: hdl/clcd_dp.sv
// ----------------------------------------------------------------------------
// clcd_dp
// Datapath: cursor register, command latch, word counter and the output
// word register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_dp #(
	parameter int LINE_CHARS = clcd_pkg::LINE_CHARS_DEF,
	parameter int COL_W      = $clog2(LINE_CHARS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [3:0]            func,
	input  logic [7:0]            char_code,
	input  logic [1:0]            req_row,
	input  logic [4:0]            req_column,
	input  clcd_pkg::ctrl_cmd_t   ctrl,
	output clcd_pkg::dp_status_t  status,
	output logic [1:0]            bus_kind,
	output logic [7:0]            bus_byte,
	output logic                  ok,
	output logic [1:0]            cur_row,
	output logic [COL_W-1:0]      cur_column,
	output logic                  last
);
	import clcd_pkg::*;

	localparam int ADDR_W = $clog2(2 * LINE_CHARS + 1);
	localparam int CNT_W  = $clog2(LINE_CHARS + 1);
	localparam logic [ADDR_W-1:0] LINE_LEN  = ADDR_W'(LINE_CHARS);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(2 * LINE_CHARS);
	localparam logic [ADDR_W-1:0] ONE       = ADDR_W'(1);

	// latched command
	logic [3:0]        func_q;
	logic [7:0]        char_q;
	logic [1:0]        row_q;
	logic [4:0]        col_q;

	// plan of the words to send
	logic [ADDR_W-1:0] cursor_q, cursor_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [7:0]        data_q, data_d;
	fin_t              fin_q, fin_d;
	logic              ok_q, ok_d;

	// output word
	logic [1:0]        kind_q;
	logic [7:0]        byte_q;
	logic              wok_q;
	logic [1:0]        row_out_q;
	logic [COL_W-1:0]  col_out_q;
	logic              last_q;

	logic              row2;
	logic [ADDR_W-1:0] col_a;
	logic [ADDR_W-1:0] col_m1;
	logic [ADDR_W-1:0] eol_end;
	logic [ADDR_W-1:0] set_col;
	logic              set_ok;
	logic [7:0]        addr_byte;
	logic [1:0]        item_kind;
	logic [7:0]        item_byte;

	// cursor position split into row and column
	assign row2      = cursor_q > LINE_LEN;
	assign col_a     = row2 ? (cursor_q - LINE_LEN) : cursor_q;
	assign col_m1    = col_a - ONE;
	assign addr_byte = {1'b1, row2, ADDR_FIELD_W'(col_m1)};
	assign eol_end   = row2 ? LAST_CELL : LINE_LEN;
	assign set_col   = ADDR_W'(col_q);
	assign set_ok    = (col_q != 5'd0) && (set_col <= LINE_LEN) &&
		((row_q == ROW_TOP) || (row_q == ROW_BOTTOM));

	// command decode and cursor update
	always_comb begin
		cursor_d = cursor_q;
		cnt_d    = '0;
		data_d   = char_q;
		fin_d    = FIN_NONE;
		ok_d     = 1'b0;
		unique case (func_q)
			FN_PUT_CHAR: begin
				if (is_printable(char_q)) begin
					cursor_d = (cursor_q == LAST_CELL) ? ONE : (cursor_q + ONE);
					cnt_d    = CNT_W'(1);
					fin_d    = FIN_ADDR;
					ok_d     = 1'b1;
				end
			end
			FN_CLEAR: begin
				cursor_d = ONE;
				fin_d    = FIN_CLEAR;
				ok_d     = 1'b1;
			end
			FN_CLEAR_EOL: begin
				cnt_d  = CNT_W'(eol_end - cursor_q + ONE);
				data_d = CHAR_SPACE;
				fin_d  = FIN_ADDR;
				ok_d   = 1'b1;
			end
			FN_UP: begin
				if (row2) begin
					cursor_d = cursor_q - LINE_LEN;
					fin_d    = FIN_ADDR;
					ok_d     = 1'b1;
				end
			end
			FN_DOWN: begin
				if (!row2) begin
					cursor_d = cursor_q + LINE_LEN;
					fin_d    = FIN_ADDR;
					ok_d     = 1'b1;
				end
			end
			FN_RIGHT: begin
				if (cursor_q < LAST_CELL) begin
					cursor_d = cursor_q + ONE;
					fin_d    = FIN_ADDR;
					ok_d     = 1'b1;
				end
			end
			FN_LEFT: begin
				if (cursor_q > ONE) begin
					cursor_d = cursor_q - ONE;
					fin_d    = FIN_ADDR;
					ok_d     = 1'b1;
				end
			end
			FN_SET_POS: begin
				if (set_ok) begin
					cursor_d = (row_q == ROW_TOP) ? set_col : (set_col + LINE_LEN);
					fin_d    = FIN_ADDR;
					ok_d     = 1'b1;
				end
			end
			FN_GET_POS: begin
				ok_d = 1'b1;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	// next word: repeated data bytes first, then the closing word
	always_comb begin
		item_kind = BUS_NONE;
		item_byte = 8'h00;
		if (cnt_q != '0) begin
			item_kind = BUS_DATA;
			item_byte = data_q;
		end else begin
			case (fin_q)
				FIN_ADDR: begin
					item_kind = BUS_INSTR;
					item_byte = addr_byte;
				end
				FIN_CLEAR: begin
					item_kind = BUS_INSTR;
					item_byte = INSTR_CLEAR;
				end
				default: begin
					item_kind = BUS_NONE;
					item_byte = 8'h00;
				end
			endcase
		end
	end

	// cursor and word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= ONE;
			cnt_q    <= '0;
		end else if (ctrl.exec) begin
			cursor_q <= cursor_d;
			cnt_q    <= cnt_d;
		end else if (ctrl.push && (cnt_q != '0)) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// command latch and plan
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			func_q <= func;
			char_q <= char_code;
			row_q  <= req_row;
			col_q  <= req_column;
		end
		if (ctrl.exec) begin
			data_q <= data_d;
			fin_q  <= fin_d;
			ok_q   <= ok_d;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			kind_q    <= item_kind;
			byte_q    <= item_byte;
			wok_q     <= ok_q;
			row_out_q <= row2 ? ROW_BOTTOM : ROW_TOP;
			col_out_q <= COL_W'(col_a);
			last_q    <= (cnt_q == '0);
		end
	end

	assign status.more = (cnt_q != '0);
	assign bus_kind    = kind_q;
	assign bus_byte    = byte_q;
	assign ok          = wok_q;
	assign cur_row     = row_out_q;
	assign cur_column  = col_out_q;
	assign last        = last_q;

endmodule

`default_nettype wire

FILE: hdl/char_lcd_cursor_controller.sv
// ----------------------------------------------------------------------------
// Cursor controller for a two-line character display.
// cmd channel: one command per word (func, char_code, req_row, req_column).
// res channel: one display bus write per word (bus_kind, bus_byte) with the
//   command status (ok, cur_row, cur_column); last marks the final word.
// Every command gives at least one word. Put char gives a data write and a
//   set-address instruction, clear gives the clear instruction, clear to end
//   of line gives one space per remaining cell of the row and then the
//   set-address instruction, moves and set position give one set-address
//   instruction; failures and get position give one no-write word.
// Timing: a taken command passes through the command latch, the cursor
//   update and the output register before its first word is valid, then
//   one word per cycle while res.ready is high. The longest command is
//   clear to end of line at column 1.
// cmd.ready is high only between commands; the final word of a command may
//   still wait in the output register while the next command is taken.
// When the receiver stalls, the output word holds and the sequencer waits.
// Reset puts the cursor at row 1, column 1 with no word pending.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_cursor_controller #(
	parameter int LINE_CHARS = clcd_pkg::LINE_CHARS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	clcd_cmd_if.sink      cmd,
	clcd_res_if.source    res
);
	import clcd_pkg::*;

	localparam int COL_W = $clog2(LINE_CHARS + 1);

	ctrl_cmd_t  ctrl;
	dp_status_t status;

	// sequencer
	clcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.ctrl      (ctrl)
	);

	// cursor datapath
	clcd_dp #(
		.LINE_CHARS (LINE_CHARS),
		.COL_W      (COL_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (cmd.func),
		.char_code  (cmd.char_code),
		.req_row    (cmd.req_row),
		.req_column (cmd.req_column),
		.ctrl       (ctrl),
		.status     (status),
		.bus_kind   (res.bus_kind),
		.bus_byte   (res.bus_byte),
		.ok         (res.ok),
		.cur_row    (res.cur_row),
		.cur_column (res.cur_column),
		.last       (res.last)
	);

endmodule

`default_nettype wire

FILE: hdl/clcd_checker.sv
// ----------------------------------------------------------------------------
// clcd_checker
// Port-level checks of the cursor controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_cursor_controller_assert.svh"

module clcd_checker #(
	parameter int COL_W = clcd_pkg::COL_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_ready,
	input  logic             res_valid,
	input  logic             res_ready,
	input  logic [1:0]       bus_kind,
	input  logic [7:0]       bus_byte,
	input  logic             ok,
	input  logic [1:0]       cur_row,
	input  logic [COL_W-1:0] cur_column,
	input  logic             last
);
	import clcd_pkg::*;

	logic [COL_W+13:0] res_word;

	// whole output word for the hold check
	assign res_word = {bus_kind, bus_byte, ok, cur_row, cur_column, last};

	// a stalled word holds
	`CLCD_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word))

	// a no-write word is the only word of its command and carries a zero byte
	`CLCD_ASSERT_IMP(a_none_last, res_valid && (bus_kind == BUS_NONE), last && (bus_byte == 8'h00))

	// a failed command never writes the bus
	`CLCD_ASSERT_IMP(a_fail_none, res_valid && !ok, bus_kind == BUS_NONE)

	// no new command is taken while the current one still has words to send
	`CLCD_ASSERT_IMP(a_busy, res_valid && !last, !cmd_ready)

endmodule

bind char_lcd_cursor_controller clcd_checker #(
	.COL_W (COL_W)
) u_clcd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_ready  (cmd.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.bus_kind   (res.bus_kind),
	.bus_byte   (res.bus_byte),
	.ok         (res.ok),
	.cur_row    (res.cur_row),
	.cur_column (res.cur_column),
	.last       (res.last)
);

`default_nettype wire
